[hdl/sule_pkg.sv]
// Shared constants and types for the SET/UA link establishment block.
package sule_pkg;

   localparam int TimeoutWidth = 16;
   localparam int TriesWidth   = 3;
   localparam int ByteWidth    = 8;
   localparam int StateWidth   = 2;
   localparam int CmdWidth     = 2;
   localparam int CsrIdxWidth  = 3;
   localparam int CsrDataWidth = 16;
   localparam int BeatWidth    = 3;

   localparam logic [ByteWidth-1:0] FRAME_FLAG = 8'h7E;

   // Command codes carried on the request side.
   localparam logic [CmdWidth-1:0] CMD_START = 2'd0;
   localparam logic [CmdWidth-1:0] CMD_BYTE  = 2'd1;
   localparam logic [CmdWidth-1:0] CMD_TICK  = 2'd2;

   // Link status codes.
   localparam logic [StateWidth-1:0] LINK_IDLE = 2'd0;
   localparam logic [StateWidth-1:0] LINK_WAIT = 2'd1;
   localparam logic [StateWidth-1:0] LINK_CONN = 2'd2;
   localparam logic [StateWidth-1:0] LINK_FAIL = 2'd3;

   // Frame recogniser states.
   localparam logic [2:0] PS_HUNT    = 3'd0;
   localparam logic [2:0] PS_ADDRESS = 3'd1;
   localparam logic [2:0] PS_CONTROL = 3'd2;
   localparam logic [2:0] PS_CHECK   = 3'd3;
   localparam logic [2:0] PS_CLOSE   = 3'd4;

   // Configuration register indexes.
   localparam logic [CsrIdxWidth-1:0] REG_TIMEOUT    = 3'd0;
   localparam logic [CsrIdxWidth-1:0] REG_MAX_TRIES  = 3'd1;
   localparam logic [CsrIdxWidth-1:0] REG_TX_ADDRESS = 3'd2;
   localparam logic [CsrIdxWidth-1:0] REG_TX_CONTROL = 3'd3;
   localparam logic [CsrIdxWidth-1:0] REG_RX_ADDRESS = 3'd4;
   localparam logic [CsrIdxWidth-1:0] REG_RX_CONTROL = 3'd5;

   // Frame beat positions.
   localparam logic [BeatWidth-1:0] BEAT_OPEN    = 3'd0;
   localparam logic [BeatWidth-1:0] BEAT_ADDRESS = 3'd1;
   localparam logic [BeatWidth-1:0] BEAT_CONTROL = 3'd2;
   localparam logic [BeatWidth-1:0] BEAT_CHECK   = 3'd3;
   localparam logic [BeatWidth-1:0] BEAT_CLOSE   = 3'd4;

   // Description of the results caused by one accepted item.
   typedef struct packed {
      logic                  frame;       // five SET bytes, otherwise one status result
      logic [StateWidth-1:0] link_state;
      logic [TriesWidth-1:0] tries_used;
   } rsp_desc_type;

endpackage

[hdl/sule_rsp_out.sv]
// Result stage: a holding register and an output register that expand descriptors into beats.
module sule_rsp_out (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push_valid,
   input  sule_pkg::rsp_desc_type              push_desc,
   output logic                                push_ready,
   input  logic [sule_pkg::ByteWidth-1:0]      tx_address,
   input  logic [sule_pkg::ByteWidth-1:0]      tx_control,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [15:0]                         rsp_tdata,
   output logic                                rsp_tuser,
   output logic                                rsp_tlast
);

   logic                             pend_valid_ff, pend_valid_in;
   sule_pkg::rsp_desc_type           pend_desc_ff, pend_desc_in;
   logic                             out_valid_ff, out_valid_in;
   sule_pkg::rsp_desc_type           out_desc_ff, out_desc_in;
   logic [sule_pkg::BeatWidth-1:0]   beat_ff, beat_in;
   logic                             final_beat;
   logic                             out_done;
   logic                             load_out;
   logic [sule_pkg::ByteWidth-1:0]   tx_byte;

   assign final_beat = !out_desc_ff.frame || (beat_ff == sule_pkg::BEAT_CLOSE);
   assign out_done   = out_valid_ff && rsp_tready && final_beat;
   assign load_out   = !out_valid_ff || out_done;
   assign push_ready = !pend_valid_ff;

   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_desc_in  = pend_desc_ff;
      out_valid_in  = out_valid_ff;
      out_desc_in   = out_desc_ff;
      beat_in       = beat_ff;
      if (load_out) begin
         beat_in = sule_pkg::BEAT_OPEN;
         if (pend_valid_ff) begin
            out_valid_in  = 1'b1;
            out_desc_in   = pend_desc_ff;
            pend_valid_in = 1'b0;
         end else if (push_valid) begin
            out_valid_in = 1'b1;
            out_desc_in  = push_desc;
         end else begin
            out_valid_in = 1'b0;
         end
      end else begin
         if (rsp_tready) begin
            beat_in = beat_ff + 1'b1;
         end
         if (push_valid && !pend_valid_ff) begin
            pend_valid_in = 1'b1;
            pend_desc_in  = push_desc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         beat_ff       <= sule_pkg::BEAT_OPEN;
      end else begin
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
         beat_ff       <= beat_in;
      end
      pend_desc_ff <= pend_desc_in;
      out_desc_ff  <= out_desc_in;
   end

   always_comb begin
      tx_byte = '0;
      if (out_desc_ff.frame) begin
         unique case (beat_ff)
            sule_pkg::BEAT_OPEN:    tx_byte = sule_pkg::FRAME_FLAG;
            sule_pkg::BEAT_ADDRESS: tx_byte = tx_address;
            sule_pkg::BEAT_CONTROL: tx_byte = tx_control;
            sule_pkg::BEAT_CHECK:   tx_byte = tx_address ^ tx_control;
            default:                tx_byte = sule_pkg::FRAME_FLAG;
         endcase
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_desc_ff.frame;
   assign rsp_tlast  = final_beat;
   assign rsp_tdata  = {3'b000, out_desc_ff.tries_used, out_desc_ff.link_state, tx_byte};

endmodule

[hdl/set_ua_link_establish_unit.sv]
// Top level of the SET/UA link establishment block: registers, link control and recogniser.
//
// The request channel carries one command per transfer: start link, one received byte
// or one timer tick (command in req_tuser, received byte in req_tdata). A start, or a
// timeout that still has tries left, produces five result transfers holding the SET
// frame bytes (flag, address, control, address xor control, flag) with tuser high and
// tlast on the closing flag. Every other command produces a single status transfer
// with tuser low, a zero byte and tlast high. Each result carries the link state and
// the number of SET frames sent, as they stand after the command.
// The link state is updated in the cycle a request is accepted; its results appear on
// the result channel on the next cycle when that channel is free. A status result
// occupies the output register as one beat and a SET frame as five, the output
// register emitting one byte per cycle while the receiver is ready. Status results
// alone flow at one transfer per cycle. While a frame drains, one further request is
// taken into the holding register and req_tready then stays low until the output
// register takes that descriptor over, so the next request waits for the frame to drain.
// When the receiver stalls, the holding register fills and req_tready falls.
// Synchronous reset restores the register defaults, returns the link to idle and
// empties both result registers. The configuration channel is always ready.
module set_ua_link_establish_unit (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic [1:0]  req_tuser,   // [1:0] cmd
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] tx_byte, [9:8] link_state, [12:10] tries_used
   output logic        rsp_tuser,   // [0] tx_valid
   output logic        rsp_tlast,   // last
   // configuration channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int TimeoutBits = sule_pkg::TimeoutWidth;

   // Configuration registers.
   logic [TimeoutBits-1:0]           timeout_ff;
   logic [sule_pkg::TriesWidth-1:0]  max_tries_ff;
   logic [7:0]                       tx_address_ff;
   logic [7:0]                       tx_control_ff;
   logic [7:0]                       rx_address_ff;
   logic [7:0]                       rx_control_ff;

   // Link state.
   logic [2:0]                       parser_ff, parser_in;
   logic [1:0]                       link_ff, link_in;
   logic [TimeoutBits-1:0]           ticks_ff, ticks_in;
   logic [sule_pkg::TriesWidth-1:0]  tries_ff, tries_in;

   logic                             accept;
   logic                             push_ready;
   logic                             send_frame;
   logic [TimeoutBits-1:0]           ticks_inc;
   logic [7:0]                       rx_byte;
   logic [1:0]                       cmd;
   logic [2:0]                       resync;
   sule_pkg::rsp_desc_type           push_desc;

   assign csr_ready  = 1'b1;
   assign req_tready = push_ready;
   assign accept     = req_tvalid && push_ready;
   assign rx_byte    = req_tdata;
   assign cmd        = req_tuser;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff    <= TimeoutBits'(3);
         max_tries_ff  <= 3'd3;
         tx_address_ff <= 8'd3;
         tx_control_ff <= 8'd3;
         rx_address_ff <= 8'd1;
         rx_control_ff <= 8'd7;
      end else if (csr_valid) begin
         unique case (csr_index)
            sule_pkg::REG_TIMEOUT:    timeout_ff    <= csr_wdata[TimeoutBits-1:0];
            sule_pkg::REG_MAX_TRIES:  max_tries_ff  <= csr_wdata[2:0];
            sule_pkg::REG_TX_ADDRESS: tx_address_ff <= csr_wdata[7:0];
            sule_pkg::REG_TX_CONTROL: tx_control_ff <= csr_wdata[7:0];
            sule_pkg::REG_RX_ADDRESS: rx_address_ff <= csr_wdata[7:0];
            sule_pkg::REG_RX_CONTROL: rx_control_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // A byte that breaks the frame either opens a new one (flag) or drops back to hunting.
   assign resync    = (rx_byte == sule_pkg::FRAME_FLAG) ? sule_pkg::PS_ADDRESS
                                                        : sule_pkg::PS_HUNT;
   assign ticks_inc = ticks_ff + 1'b1;

   always_comb begin
      parser_in  = parser_ff;
      link_in    = link_ff;
      ticks_in   = ticks_ff;
      tries_in   = tries_ff;
      send_frame = 1'b0;
      if (cmd == sule_pkg::CMD_START) begin
         parser_in  = sule_pkg::PS_HUNT;
         ticks_in   = '0;
         tries_in   = 3'd1;
         link_in    = sule_pkg::LINK_WAIT;
         send_frame = 1'b1;
      end else if (cmd == sule_pkg::CMD_BYTE && link_ff == sule_pkg::LINK_WAIT) begin
         unique case (parser_ff)
            sule_pkg::PS_HUNT:
               if (rx_byte == sule_pkg::FRAME_FLAG) parser_in = sule_pkg::PS_ADDRESS;
            sule_pkg::PS_ADDRESS:
               parser_in = (rx_byte == rx_address_ff) ? sule_pkg::PS_CONTROL : resync;
            sule_pkg::PS_CONTROL:
               parser_in = (rx_byte == rx_control_ff) ? sule_pkg::PS_CHECK : resync;
            sule_pkg::PS_CHECK:
               parser_in = (rx_byte == (rx_address_ff ^ rx_control_ff))
                           ? sule_pkg::PS_CLOSE : resync;
            sule_pkg::PS_CLOSE: begin
               parser_in = sule_pkg::PS_HUNT;
               if (rx_byte == sule_pkg::FRAME_FLAG) link_in = sule_pkg::LINK_CONN;
            end
            default: parser_in = sule_pkg::PS_HUNT;
         endcase
      end else if (cmd == sule_pkg::CMD_TICK && link_ff == sule_pkg::LINK_WAIT) begin
         ticks_in = ticks_inc;
         if (ticks_inc >= timeout_ff) begin
            ticks_in = '0;
            if (tries_ff < max_tries_ff) begin
               tries_in   = tries_ff + 1'b1;
               send_frame = 1'b1;
            end else begin
               link_in = sule_pkg::LINK_FAIL;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         parser_ff <= sule_pkg::PS_HUNT;
         link_ff   <= sule_pkg::LINK_IDLE;
         ticks_ff  <= '0;
         tries_ff  <= '0;
      end else if (accept) begin
         parser_ff <= parser_in;
         link_ff   <= link_in;
         ticks_ff  <= ticks_in;
         tries_ff  <= tries_in;
      end
   end

   assign push_desc.frame      = send_frame;
   assign push_desc.link_state = link_in;
   assign push_desc.tries_used = tries_in;

   sule_rsp_out u_rsp_out (
      .clock      (clock),
      .reset      (reset),
      .push_valid (accept),
      .push_desc  (push_desc),
      .push_ready (push_ready),
      .tx_address (tx_address_ff),
      .tx_control (tx_control_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
